/* rtl/nfo_pll_pkg.sv */
// ----------------------------------------------------------------------------
// Flux observer package
// Shared types, constants and helper functions for the flux observer with PLL.
// ----------------------------------------------------------------------------
package nfo_pll_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } nfo_state_t;

  typedef enum logic [2:0] {
    CFG_RS  = 3'd0,
    CFG_LS  = 3'd1,
    CFG_TS  = 3'd2,
    CFG_FM  = 3'd3,
    CFG_G   = 3'd4,
    CFG_KP  = 3'd5,
    CFG_KI  = 3'd6,
    CFG_NUL = 3'd7
  } cfg_idx_t;

  localparam int             STEP_W     = 5;
  localparam logic [4:0]     STEP_FIRST = 5'd1;
  localparam logic [4:0]     STEP_LAST  = 5'd22;
  localparam logic signed [31:0] LPF_OLD    = 32'sd15099494;
  localparam logic signed [31:0] LPF_NEW    = 32'sd1677722;
  localparam logic signed [31:0] RAD_TURN   = 32'sd683565276;
  localparam longint         TWO_PI_Q30 = 64'sd6746518852;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic longint quarter_sine(input longint r, input int bits);
    longint x;
    longint x2;
    longint t;
    longint s;
    x  = (r * TWO_PI_Q30) >>> bits;
    x2 = (x * x) >>> 30;
    t  = x;
    s  = x;
    t  = -((t * x2) / 64'sd1073741824) / 64'sd6;
    s  = s + t;
    t  = -((t * x2) / 64'sd1073741824) / 64'sd20;
    s  = s + t;
    t  = -((t * x2) / 64'sd1073741824) / 64'sd42;
    s  = s + t;
    t  = -((t * x2) / 64'sd1073741824) / 64'sd72;
    s  = s + t;
    t  = -((t * x2) / 64'sd1073741824) / 64'sd110;
    s  = s + t;
    if (s < 0) begin
      s = 0;
    end
    return (s + 64'sd32) >>> 6;
  endfunction

  function automatic logic signed [31:0] sine_entry(input int k, input int bits);
    int     quarter;
    int     q;
    int     r;
    longint v;
    quarter = (1 << bits) >> 2;
    q = k >> (bits - 2);
    r = k & (quarter - 1);
    if (q[0]) begin
      v = quarter_sine(longint'(quarter - r), bits);
    end else begin
      v = quarter_sine(longint'(r), bits);
    end
    if (q[1]) begin
      v = -v;
    end
    return v[31:0];
  endfunction

endpackage

/* rtl/nonlinear_flux_observer_pll.sv */
// ----------------------------------------------------------------------------
// Nonlinear flux observer with PLL
// Sensorless rotor angle and speed estimation from alpha/beta voltage and
// current, with one shared multiplier driven by a step sequencer.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one alpha/beta voltage and current sample per
// transaction. The result channel returns the electrical angle, the filtered
// speed and the magnet flux estimate for that sample.
// Registers are written through cfg_we, cfg_index and cfg_data; the user is to
// write them only while the block is idle, which the block does not enforce.
// A write to an unused index is dropped. Each transaction runs 22 steps
// through one 32x32 multiplier. A new input can be taken in the cycle after
// the result is taken.
// The block holds one transaction at a time: in_ready is low while a sample
// is being worked on and while a result waits. If the receiver stalls, the
// result holds and no input is taken.
// Reset clears the registers, the observer and PLL state, and the handshake.
// ----------------------------------------------------------------------------
module nonlinear_flux_observer_pll
  import nfo_pll_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_volt_alpha,
  input  logic signed [31:0] in_volt_beta,
  input  logic signed [31:0] in_curr_alpha,
  input  logic signed [31:0] in_curr_beta,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_electrical_angle,
  output logic signed [31:0] out_electrical_speed,
  output logic signed [31:0] out_magnet_flux_alpha,
  output logic signed [31:0] out_magnet_flux_beta
);

  localparam int TAB_N = 1 << SINE_TABLE_BITS;
  localparam int TAB_Q = TAB_N / 4;

  logic signed [31:0] sine_lut [TAB_N];

  for (genvar k = 0; k < TAB_N; k++) begin : g_lut
    assign sine_lut[k] = sine_entry(k, SINE_TABLE_BITS);
  end

  nfo_state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r;

  logic [30:0] rs_r, ls_r, ts_r, fm_r, g_r, kp_r, ki_r;

  logic signed [31:0] va_r, vb_r, ia_r, ib_r;
  logic signed [31:0] fa_r, fb_r, integ_r, speed_r;
  logic [15:0]        angle_r;
  logic signed [31:0] lia_r, lib_r, y1_r, y2_r, e1_r, e2_r, err_r;
  logic signed [31:0] d1_r, d2_r, ma_r, mb_r, aerr_r, p_r;
  logic [63:0]        acc_r;
  logic signed [63:0] prod_r;

  logic signed [31:0] mul_a, mul_b;
  logic signed [31:0] qv, ma_c, mb_c, aerr_c, omega_c, speed_c;
  logic signed [63:0] err_wide;
  logic signed [31:0] fm_s, sn, cs;
  logic [SINE_TABLE_BITS-1:0] sin_idx, cos_idx;

  assign sin_idx = angle_r[15 -: SINE_TABLE_BITS];
  assign cos_idx = sin_idx + SINE_TABLE_BITS'(TAB_Q);
  assign sn      = sine_lut[sin_idx];
  assign cs      = sine_lut[cos_idx];
  assign fm_s    = signed'({1'b0, fm_r});

  assign qv      = sat32(prod_r >>> 24);
  assign ma_c    = sat32(64'(fa_r) - 64'(lia_r));
  assign mb_c    = sat32(64'(fb_r) - 64'(lib_r));
  assign aerr_c  = sat32((prod_r - signed'(acc_r)) >>> 24);
  assign omega_c = sat32(64'(p_r) + 64'(integ_r));
  assign speed_c = sat32((signed'(acc_r) + prod_r) >>> 24);
  assign err_wide = (prod_r >>> 24) - signed'({24'd0, acc_r[63:24]});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      5'd1:    begin mul_a = signed'({1'b0, ls_r}); mul_b = ia_r;     end
      5'd2:    begin mul_a = signed'({1'b0, ls_r}); mul_b = ib_r;     end
      5'd3:    begin mul_a = signed'({1'b0, rs_r}); mul_b = ia_r;     end
      5'd4:    begin mul_a = signed'({1'b0, rs_r}); mul_b = ib_r;     end
      5'd5:    begin mul_a = e1_r;                  mul_b = e1_r;     end
      5'd6:    begin mul_a = e2_r;                  mul_b = e2_r;     end
      5'd7:    begin mul_a = fm_s;                  mul_b = fm_s;     end
      5'd8:    begin mul_a = signed'({1'b0, g_r});  mul_b = e1_r;     end
      5'd9:    begin mul_a = qv;                    mul_b = err_r;    end
      5'd10:   begin mul_a = signed'({1'b0, g_r});  mul_b = e2_r;     end
      5'd11:   begin mul_a = qv;                    mul_b = err_r;    end
      5'd12:   begin mul_a = d1_r; mul_b = signed'({1'b0, ts_r});     end
      5'd13:   begin mul_a = d2_r; mul_b = signed'({1'b0, ts_r});     end
      5'd14:   begin mul_a = ma_c;                  mul_b = sn;       end
      5'd15:   begin mul_a = mb_c;                  mul_b = cs;       end
      5'd16:   begin mul_a = signed'({1'b0, kp_r}); mul_b = aerr_c;   end
      5'd17:   begin mul_a = signed'({1'b0, ki_r}); mul_b = aerr_r;   end
      5'd18:   begin mul_a = speed_r;               mul_b = LPF_OLD;  end
      5'd19:   begin mul_a = omega_c;               mul_b = LPF_NEW;  end
      5'd20:   begin mul_a = speed_c; mul_b = signed'({1'b0, ts_r});  end
      5'd21:   begin mul_a = qv;                    mul_b = RAD_TURN; end
      default: begin mul_a = '0;                    mul_b = '0;       end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_r == STEP_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (state_r == ST_IDLE && in_valid) begin
      step_r <= STEP_FIRST;
    end else if (state_r == ST_RUN && step_r != STEP_LAST) begin
      step_r <= step_r + 5'd1;
    end else if (state_r != ST_RUN) begin
      step_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r <= '0;
      ls_r <= '0;
      ts_r <= '0;
      fm_r <= '0;
      g_r  <= '0;
      kp_r <= '0;
      ki_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RS:  rs_r <= cfg_data;
        CFG_LS:  ls_r <= cfg_data;
        CFG_TS:  ts_r <= cfg_data;
        CFG_FM:  fm_r <= cfg_data;
        CFG_G:   g_r  <= cfg_data;
        CFG_KP:  kp_r <= cfg_data;
        CFG_KI:  ki_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_r    <= '0;
      fb_r    <= '0;
      integ_r <= '0;
      speed_r <= '0;
      angle_r <= '0;
    end else if (state_r == ST_RUN) begin
      case (step_r)
        5'd13:   fa_r    <= sat32(64'(fa_r) + 64'(qv));
        5'd14:   fb_r    <= sat32(64'(fb_r) + 64'(qv));
        5'd18:   integ_r <= sat32(64'(integ_r) + 64'(qv));
        5'd20:   speed_r <= speed_c;
        5'd22:   angle_r <= angle_r + prod_r[55:40];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    if (state_r == ST_IDLE && in_valid) begin
      va_r <= in_volt_alpha;
      vb_r <= in_volt_beta;
      ia_r <= in_curr_alpha;
      ib_r <= in_curr_beta;
    end
    if (state_r == ST_RUN) begin
      case (step_r)
        5'd2:  lia_r <= qv;
        5'd3: begin
          lib_r <= qv;
          e1_r  <= sat32(64'(fa_r) - 64'(lia_r));
          e2_r  <= sat32(64'(fb_r) - 64'(qv));
        end
        5'd4:  y1_r  <= sat32(64'(va_r) - 64'(qv));
        5'd5:  y2_r  <= sat32(64'(vb_r) - 64'(qv));
        5'd6:  acc_r <= prod_r;
        5'd7:  acc_r <= acc_r + prod_r;
        5'd8: begin
          if (err_wide > 64'(fm_s)) begin
            err_r <= fm_s;
          end else if (err_wide < -64'(fm_s)) begin
            err_r <= -fm_s;
          end else begin
            err_r <= err_wide[31:0];
          end
        end
        5'd10: d1_r <= sat32(64'(y1_r) + 64'(qv));
        5'd12: d2_r <= sat32(64'(y2_r) + 64'(qv));
        5'd14: ma_r <= ma_c;
        5'd15: begin
          acc_r <= prod_r;
          mb_r  <= mb_c;
        end
        5'd16: aerr_r <= aerr_c;
        5'd17: p_r    <= qv;
        5'd19: acc_r  <= prod_r;
        default: ;
      endcase
    end
  end

  assign out_electrical_angle  = angle_r;
  assign out_electrical_speed  = speed_r;
  assign out_magnet_flux_alpha = ma_r;
  assign out_magnet_flux_beta  = mb_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("Input taken while a result is pending.");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid)
    else $error("Result shown right after an input transaction.");

  a_return_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> in_ready)
    else $error("Block did not return to idle after the result was taken.");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (step_r >= STEP_FIRST && step_r <= STEP_LAST))
    else $error("Sequencer step out of range.");

endmodule
